FILE: sv/sta_pkg.sv
// Package for the stick trim adjuster: word types, sizes, register indexes
// and reset values. Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package sta_pkg;

    localparam int CHANNELS = 8;
    localparam int SLOTS    = 10;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int TRIM_W   = 16;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 2;

    localparam logic [11:0] FINE_THRESHOLD_RST   = 12'd150;
    localparam logic [11:0] COARSE_THRESHOLD_RST = 12'd600;
    localparam logic [7:0]  FINE_STEP_RST        = 8'd1;
    localparam logic [7:0]  COARSE_STEP_RST      = 8'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FINE_THRESHOLD   = 2'd0,
        REG_COARSE_THRESHOLD = 2'd1,
        REG_FINE_STEP        = 2'd2,
        REG_COARSE_STEP      = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0]        channel;
        logic [14:0]       pulse;
        logic              trim_switch;
        logic              clear_switch;
        logic signed [3:0] excepted_channel;
        logic [3:0]        slot_select;
    } pulse_word_t;

    typedef struct packed {
        logic [2:0]               channel_out;
        logic [14:0]              pulse_out;
        logic signed [TRIM_W-1:0] trim_value;
        logic                     trim_active;
        logic                     resync;
    } result_word_t;

    // What the current frame does, decided on its channel 0 word.
    typedef struct packed {
        logic clear;
        logic latch;
        logic trim;
    } frame_act_t;

    typedef logic [CHANNELS-1:0][TRIM_W-1:0] trim_row_t;

endpackage

FILE: sv/stick_trim_adjuster.sv
// Top level of the stick trim adjuster: input register, trim logic, slot
// store and result register. Depends on sta_pkg.
`timescale 1ns / 1ps

// The block takes one channel pulse word per cycle while the result side is not
// stalled, and returns one result word for each; each word is held in the input
// register and then in the result register, with the single pass of trim
// logic between those two registers. A frame starts at channel 0, whose word
// samples the slot, trim and clear switches. The trim store keeps one row of
// all channel trims per slot in registers, with a valid bit per row, so it
// reads as zero after reset without any clearing pass. Configuration writes
// are always ready and must only be issued while the block is idle.
module stick_trim_adjuster
    import sta_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pulse_valid,
    output logic                 pulse_stall,
    input  pulse_word_t          pulse_word,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_word_t         result_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Configuration registers.
    logic [11:0] fine_threshold_reg;
    logic [11:0] coarse_threshold_reg;
    logic [7:0]  fine_step_reg;
    logic [7:0]  coarse_step_reg;

    // Pipeline registers.
    logic         s1_valid_reg;
    pulse_word_t  s1_word_reg;
    logic         out_valid_reg;
    result_word_t out_word_reg;

    // Trim state.
    logic              trimming_reg, trimming_next;
    logic              armed_reg, armed_next;
    logic [SLOT_W-1:0] current_slot_reg, current_slot_next;
    frame_act_t        frame_action_reg, frame_action_next;
    trim_row_t         trims_reg, trims_next;
    logic [14:0]       centres_mem [CHANNELS];
    trim_row_t         store_mem [SLOTS];
    logic [SLOTS-1:0]  row_valid_reg;

    logic              out_free;
    logic              fire;
    logic              frame;
    logic [SLOT_W-1:0] slot_sat;
    logic              load;
    logic              save;
    trim_row_t         row_rd;
    trim_row_t         trims_ld;
    frame_act_t        act;
    logic              in_range;
    logic              apply;
    logic [14:0]       centre_eff;
    logic signed [16:0] dev;
    logic signed [16:0] fine_pos, fine_neg, coarse_pos, coarse_neg;
    logic [TRIM_W-1:0] t_new;
    logic [2:0]        ch;
    result_word_t      res;

    assign out_free    = !out_valid_reg || !result_stall;
    assign fire        = s1_valid_reg && out_free;
    assign pulse_stall = s1_valid_reg && !out_free;
    assign cfg_ready   = 1'b1;
    assign result_valid = out_valid_reg;
    assign result_word  = out_word_reg;

    assign ch    = s1_word_reg.channel;
    assign frame = (ch == 3'd0);

    always_comb
    begin
        if ({1'b0, s1_word_reg.slot_select} >= 5'(SLOTS))
            slot_sat = SLOT_W'(SLOTS - 1);
        else
            slot_sat = SLOT_W'(s1_word_reg.slot_select);
    end

    assign load   = frame && (slot_sat != current_slot_reg);
    assign row_rd = row_valid_reg[slot_sat] ? store_mem[slot_sat] : '0;

    // Frame decision, state updates and the loaded or cleared trim row for this word.
    always_comb
    begin
        trims_ld          = load ? row_rd : trims_reg;
        trimming_next     = trimming_reg;
        armed_next        = armed_reg;
        current_slot_next = frame ? slot_sat : current_slot_reg;
        frame_action_next = frame_action_reg;
        save              = 1'b0;

        if (frame) begin
            frame_action_next = '0;
            if (s1_word_reg.trim_switch) begin
                trimming_next = 1'b1;
                frame_action_next.latch = !trimming_reg;
                if (s1_word_reg.clear_switch && armed_reg) begin
                    frame_action_next.clear = 1'b1;
                end
                else begin
                    armed_next = 1'b1;
                    frame_action_next.trim = 1'b1;
                end
            end
            else if (trimming_reg) begin
                trimming_next = 1'b0;
                armed_next    = 1'b0;
                save          = 1'b1;
            end
        end

        act = frame_action_next;
        if (frame && act.clear)
            trims_ld = '0;
    end

    assign in_range   = ({2'b00, ch} < 5'(CHANNELS));
    assign centre_eff = act.latch ? s1_word_reg.pulse : centres_mem[ch];
    assign apply      = act.trim && in_range
                        && (s1_word_reg.excepted_channel != $signed({1'b0, ch}));

    assign dev        = $signed({2'b00, s1_word_reg.pulse}) - $signed({2'b00, centre_eff});
    assign fine_pos   = $signed({5'b0, fine_threshold_reg});
    assign coarse_pos = $signed({5'b0, coarse_threshold_reg});
    assign fine_neg   = -fine_pos;
    assign coarse_neg = -coarse_pos;

    // Trims wrap at 16 bits; the fine and coarse steps add up past the coarse threshold.
    always_comb
    begin
        t_new = trims_ld[ch];
        if (dev > fine_pos)
            t_new = t_new + TRIM_W'(fine_step_reg);
        if (dev > coarse_pos)
            t_new = t_new + TRIM_W'(coarse_step_reg);
        if (dev < fine_neg)
            t_new = t_new - TRIM_W'(fine_step_reg);
        if (dev < coarse_neg)
            t_new = t_new - TRIM_W'(coarse_step_reg);
    end

    always_comb
    begin
        trims_next = trims_ld;
        if (apply)
            trims_next[ch] = t_new;

        res.channel_out = ch;
        res.pulse_out   = apply ? centre_eff : s1_word_reg.pulse;
        res.trim_value  = in_range ? $signed(trims_next[ch]) : '0;
        res.trim_active = trimming_next;
        res.resync      = save;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fine_threshold_reg   <= FINE_THRESHOLD_RST;
            coarse_threshold_reg <= COARSE_THRESHOLD_RST;
            fine_step_reg        <= FINE_STEP_RST;
            coarse_step_reg      <= COARSE_STEP_RST;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                REG_FINE_THRESHOLD:   fine_threshold_reg   <= cfg_data;
                REG_COARSE_THRESHOLD: coarse_threshold_reg <= cfg_data;
                REG_FINE_STEP:        fine_step_reg        <= cfg_data[7:0];
                REG_COARSE_STEP:      coarse_step_reg      <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            trimming_reg     <= 1'b0;
            armed_reg        <= 1'b0;
            current_slot_reg <= '0;
            frame_action_reg <= '0;
            trims_reg        <= '0;
            row_valid_reg    <= '0;
        end
        else begin
            if (!pulse_stall)
                s1_valid_reg <= pulse_valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
            if (fire) begin
                trimming_reg     <= trimming_next;
                armed_reg        <= armed_next;
                current_slot_reg <= current_slot_next;
                frame_action_reg <= frame_action_next;
                trims_reg        <= trims_next;
                if (save)
                    row_valid_reg[slot_sat] <= 1'b1;
            end
        end
    end

    // Payload and stores carry no reset.
    always_ff @(posedge clk)
    begin
        if (!pulse_stall && pulse_valid)
            s1_word_reg <= pulse_word;
        if (fire)
            out_word_reg <= res;
        if (fire && in_range && act.latch)
            centres_mem[ch] <= s1_word_reg.pulse;
        if (fire && save)
            store_mem[slot_sat] <= trims_ld;
    end

endmodule

FILE: sv/sta_checker.sv
// Port-level checker for the stick trim adjuster, bound to the top level.
// Depends on sta_pkg.
`timescale 1ns / 1ps

module sta_checker
    import sta_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 pulse_stall,
    input logic                 result_valid,
    input logic                 result_stall,
    input result_word_t         result_word
);

    // A stalled result word stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_word))
        else $error("stalled result word changed");

    // The input side only backs up when the result side is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        pulse_stall |-> result_valid && result_stall)
        else $error("input stalled with room at the output");

    // Trims are saved only on a frame start word.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_word.resync |-> result_word.channel_out == 3'd0)
        else $error("resync on a word that does not start a frame");

    // Saving means trim mode has just been left.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_word.resync |-> !result_word.trim_active)
        else $error("resync while trim mode is still active");

endmodule

bind stick_trim_adjuster sta_checker u_sta_checker (.*);
